// ----- sv/sigmtr_pkg.sv -----
// Package for the signal meter: field widths, sequencer state type and
// channel packing constants. No dependencies.
package sigmtr_pkg;

    localparam int SAMPLE_W  = 12;  // converter sample, average, full scale
    localparam int ELAPSED_W = 10;  // milliseconds since previous sample
    localparam int DECAY_W   = 16;  // decay interval register
    localparam int SINCE_W   = 17;  // saturating time since last peak change
    localparam int LEVEL_W   = 6;   // internal segment count, up to 63
    localparam int SEG_OUT_W = 5;   // level and peak as delivered
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_MS   = 2'd1;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST = 12'd2000;
    localparam logic [DECAY_W-1:0]  DECAY_MS_RST   = 16'd150;
    localparam logic [SINCE_W-1:0]  SINCE_MAX      = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_SCALE,
        ST_DIV_LVL,
        ST_PEAK
    } meter_state_t;

endpackage

// ----- sv/signal_meter_average_peak_hold.sv -----
// Signal meter top level: moving average, bargraph level, peak hold.
// Depends on sigmtr_pkg; one restoring divider under a small sequencer.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------------
//  s_        | in        | s_tvalid / s_tready    | s_tdata: sample, elapsed_ms
//  m_        | out       | m_tvalid / m_tready    | m_tdata: level, peak, average
//  cfg_      | in        | cfg_valid / cfg_ready  | cfg_addr, cfg_data
//
// Steps: an accepted item passes the accept step in idle, the window average
// by reciprocal multiplication, a clamp-and-scale step, DIV_W steps of the
// one-bit-per-cycle divider (DIV_W = 18 at the default parameters) for
// scaled / full_scale, and one peak step. A zero full scale skips the divider.
// s_tready is high only in idle; a result waiting in the output register does
// not block the next transaction, but the sequencer holds its last step until
// that register is free.
// Reset (aresetn low, synchronous) clears the ring, sum, peak, timers and loads
// full_scale = 2000 and decay_interval_ms = 150. cfg_ready is always high.
module signal_meter_average_peak_hold #(
    parameter int WINDOW_LEN    = 5,
    parameter int SEGMENT_COUNT = 25
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input transaction
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [11:0] sample, [21:12] elapsed_ms, [23:22] zero
    input  logic [sigmtr_pkg::S_DATA_W-1:0]  s_tdata,
    // Result transaction
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [4:0] level, [9:5] peak, [21:10] average, [23:22] zero
    output logic [sigmtr_pkg::M_DATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sigmtr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sigmtr_pkg::CFG_DAT_W-1:0] cfg_data
);
    import sigmtr_pkg::*;

    // Widths that follow from the parameters
    localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int PROD_W = SAMPLE_W + LEVEL_W;
    localparam int DIV_W  = PROD_W;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    // Window average as (sum * AVG_MUL) >> AVG_SHIFT, exact for every sum
    localparam int AVG_SHIFT  = SUM_W + $clog2(WINDOW_LEN);
    localparam int AVG_MUL_W  = SUM_W + 1;
    localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL =
        AVG_MUL_W'(((1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);
    localparam logic [POS_W-1:0]    POS_LAST = POS_W'(WINDOW_LEN - 1);
    localparam logic [LEVEL_W-1:0]  SEG_MAX  = LEVEL_W'(SEGMENT_COUNT);
    localparam logic [CNT_W-1:0]    DIV_STEPS = CNT_W'(DIV_W);

    // Configuration registers
    logic [SAMPLE_W-1:0] fs_reg;
    logic [DECAY_W-1:0]  decay_reg;

    // Meter state
    logic [SAMPLE_W-1:0] ring_reg [WINDOW_LEN];
    logic [SUM_W-1:0]    sum_reg,   sum_next;
    logic [POS_W-1:0]    pos_reg,   pos_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [LEVEL_W-1:0]  peak_reg,  peak_next;
    logic [SINCE_W-1:0]  since_reg, since_next;
    logic [SAMPLE_W-1:0] avg_reg,   avg_next;

    // Restoring divider
    logic [DIV_W-1:0]    quo_reg,   quo_next;
    logic [SAMPLE_W-1:0] rem_reg,   rem_next;
    logic [SAMPLE_W-1:0] dvs_reg,   dvs_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;

    // Sequencer and output register
    meter_state_t        state_reg, state_next;
    logic                mvalid_reg, mvalid_next;
    logic [M_DATA_W-1:0] mdata_reg,  mdata_next;

    logic                in_fire;
    logic                ring_we;
    logic                out_load;
    logic [SAMPLE_W-1:0] in_sample;
    logic [ELAPSED_W-1:0] in_elapsed;

    // Divider step
    logic [SAMPLE_W:0]   div_shift;
    logic [SAMPLE_W:0]   div_diff;
    logic                div_ge;

    // Working values
    logic [SINCE_W:0]    since_sum;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [SAMPLE_W-1:0] clamped;
    logic [PROD_W-1:0]   scaled;
    logic [LEVEL_W-1:0]  pk_hold;
    logic [SINCE_W-1:0]  since_hold;

    assign in_sample  = s_tdata[SAMPLE_W-1:0];
    assign in_elapsed = s_tdata[SAMPLE_W +: ELAPSED_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

    // One restoring division step: shift in the next dividend bit, try subtract
    assign div_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign div_diff  = div_shift - {1'b0, dvs_reg};
    assign div_ge    = (div_shift >= {1'b0, dvs_reg});

    assign since_sum = {1'b0, since_reg} + (SINCE_W + 1)'(in_elapsed);
    assign avg_prod  = AVG_PROD_W'(sum_reg) * AVG_PROD_W'(AVG_MUL);
    assign clamped   = (avg_reg > fs_reg) ? fs_reg : avg_reg;
    assign scaled    = PROD_W'(clamped) * PROD_W'(SEG_MAX);

    // Peak follows the level up and restarts the hold timer
    always_comb begin
        if (level_reg > peak_reg) begin
            pk_hold    = level_reg;
            since_hold = '0;
        end else begin
            pk_hold    = peak_reg;
            since_hold = since_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        pos_next    = pos_reg;
        level_next  = level_reg;
        peak_next   = peak_reg;
        since_next  = since_reg;
        avg_next    = avg_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        ring_we     = 1'b0;
        out_load    = 1'b0;

        // Drop the result once the consumer takes it
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    // Replace the oldest ring entry, advance the timer with saturation
                    ring_we    = 1'b1;
                    sum_next   = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(in_sample);
                    pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                    since_next = since_sum[SINCE_W] ? SINCE_MAX : since_sum[SINCE_W-1:0];
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                // Divide the window sum by its constant length
                avg_next   = avg_prod[AVG_SHIFT +: SAMPLE_W];
                state_next = ST_SCALE;
            end
            ST_DIV_LVL: begin
                rem_next = div_ge ? div_diff[SAMPLE_W-1:0] : div_shift[SAMPLE_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    level_next = quo_next[LEVEL_W-1:0];
                    state_next = ST_PEAK;
                end
            end
            ST_SCALE: begin
                // Zero full scale lights every segment; skip the divider
                if (fs_reg == '0) begin
                    level_next = SEG_MAX;
                    state_next = ST_PEAK;
                end else begin
                    quo_next   = DIV_W'(scaled);
                    rem_next   = '0;
                    dvs_next   = fs_reg;
                    cnt_next   = DIV_STEPS;
                    state_next = ST_DIV_LVL;
                end
            end
            ST_PEAK: begin
                // Hold until the output register is free
                if (!mvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    if (since_hold > SINCE_W'(decay_reg)) begin
                        peak_next  = (pk_hold == '0) ? '0 : pk_hold - 1'b1;
                        since_next = '0;
                    end else begin
                        peak_next  = pk_hold;
                        since_next = since_hold;
                    end
                    mvalid_next = 1'b1;
                    mdata_next  = M_DATA_W'({avg_reg,
                                             peak_next[SEG_OUT_W-1:0],
                                             level_reg[SEG_OUT_W-1:0]});
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sum_reg    <= '0;
            pos_reg    <= '0;
            level_reg  <= '0;
            peak_reg   <= '0;
            since_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            pos_reg    <= pos_next;
            level_reg  <= level_next;
            peak_reg   <= peak_next;
            since_reg  <= since_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Datapath registers without reset
    always_ff @(posedge aclk) begin
        avg_reg   <= avg_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        cnt_reg   <= cnt_next;
        mdata_reg <= mdata_next;
    end

    // Sample ring, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (ring_we) begin
            ring_reg[pos_reg] <= in_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg    <= FULL_SCALE_RST;
            decay_reg <= DECAY_MS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_FULL_SCALE: fs_reg    <= cfg_data[SAMPLE_W-1:0];
                CFG_DECAY_MS:   decay_reg <= cfg_data[DECAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Checks on the sequencer and datapath
    a_accept_starts_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_AVG))
        else $error("accepted transaction did not start the window average");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_LVL) |-> (rem_reg < dvs_reg))
        else $error("divider remainder reached the divisor");

    a_level_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (level_reg <= SEG_MAX) && (peak_reg <= SEG_MAX))
        else $error("level or peak beyond segment count");

    a_timer_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (since_reg <= SINCE_W'($past(decay_reg))))
        else $error("hold timer above decay interval after a result");

    a_result_loaded_once: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (mvalid_reg && state_reg == ST_IDLE))
        else $error("result not presented after the peak step");

endmodule

// ----- tb/signal_meter_average_peak_hold_checker.sv -----
// Checker for the signal meter: watches the input, result and configuration
// channels, predicts each reading and compares it field by field.
// Depends on sigmtr_pkg for widths, register indexes and reset values.
module signal_meter_average_peak_hold_checker
    import sigmtr_pkg::*;
#(
    parameter int WINDOW_LEN    = 5,
    parameter int SEGMENT_COUNT = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   mismatch_count,
    output int                   readings_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    typedef struct {
        logic [SEG_OUT_W-1:0] level;
        logic [SEG_OUT_W-1:0] peak;
        logic [SAMPLE_W-1:0]  average;
    } meter_reading_t;

    // Shadow of the meter state and its two registers
    logic [SAMPLE_W-1:0] ring_copy [WINDOW_LEN];
    int unsigned         sum_copy;
    logic [POS_W-1:0]    pos_copy;
    int unsigned         peak_copy;
    int unsigned         since_copy;
    int unsigned         full_scale_copy;
    int unsigned         decay_copy;

    meter_reading_t      readings_q [$];
    int                  errs = 0;

    function automatic meter_reading_t predict_reading(input logic [SAMPLE_W-1:0]  smp,
                                                       input logic [ELAPSED_W-1:0] elapsed);
        meter_reading_t r;
        int unsigned    avg;
        int unsigned    clamped;
        int unsigned    lvl;
        since_copy = since_copy + 32'(elapsed);
        if (since_copy > 32'(SINCE_MAX)) since_copy = 32'(SINCE_MAX);

        sum_copy = sum_copy - 32'(ring_copy[pos_copy]) + 32'(smp);
        ring_copy[pos_copy] = smp;
        pos_copy = (pos_copy == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_copy + 1'b1;
        avg = sum_copy / WINDOW_LEN;

        if (full_scale_copy == 0) begin
            lvl = SEGMENT_COUNT;
        end else begin
            clamped = (avg > full_scale_copy) ? full_scale_copy : avg;
            lvl = clamped * SEGMENT_COUNT / full_scale_copy;
        end

        // Follow upward, then decay one segment once the hold time has run out
        if (lvl > peak_copy) begin
            peak_copy  = lvl;
            since_copy = 0;
        end
        if (since_copy > decay_copy) begin
            if (peak_copy > 0) peak_copy--;
            since_copy = 0;
        end

        r.level   = lvl[SEG_OUT_W-1:0];
        r.peak    = peak_copy[SEG_OUT_W-1:0];
        r.average = avg[SAMPLE_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        meter_reading_t got;
        meter_reading_t want;
        if (!aresetn) begin
            foreach (ring_copy[i]) ring_copy[i] = '0;
            sum_copy        = 0;
            pos_copy        = '0;
            peak_copy       = 0;
            since_copy      = 0;
            full_scale_copy = 32'(FULL_SCALE_RST);
            decay_copy      = 32'(DECAY_MS_RST);
            readings_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_FULL_SCALE: full_scale_copy = 32'(cfg_data[SAMPLE_W-1:0]);
                    CFG_DECAY_MS:   decay_copy      = 32'(cfg_data[DECAY_W-1:0]);
                    default: ;
                endcase
            end
            // Compare before pushing so a reading never meets its own prediction
            if (m_tvalid && m_tready) begin
                got.level   = m_tdata[SEG_OUT_W-1:0];
                got.peak    = m_tdata[SEG_OUT_W +: SEG_OUT_W];
                got.average = m_tdata[2*SEG_OUT_W +: SAMPLE_W];
                if (readings_q.size() == 0) begin
                    $error("result transaction with no reading due: level %0d peak %0d avg %0d",
                           got.level, got.peak, got.average);
                    errs++;
                end else begin
                    want = readings_q.pop_front();
                    if (got.level !== want.level) begin
                        $error("level mismatch: expected %0d, actual %0d", want.level, got.level);
                        errs++;
                    end
                    if (got.peak !== want.peak) begin
                        $error("peak mismatch: expected %0d, actual %0d", want.peak, got.peak);
                        errs++;
                    end
                    if (got.average !== want.average) begin
                        $error("average mismatch: expected %0d, actual %0d",
                               want.average, got.average);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                readings_q.push_back(predict_reading(s_tdata[SAMPLE_W-1:0],
                                                     s_tdata[SAMPLE_W +: ELAPSED_W]));
        end
        readings_due   <= readings_q.size();
        mismatch_count <= errs;
    end

endmodule

// ----- tb/signal_meter_average_peak_hold_tb.sv -----
// Testbench top for the signal meter: clock, reset, stimulus and verdict.
// Depends on sigmtr_pkg, the meter RTL and signal_meter_average_peak_hold_checker.
module signal_meter_average_peak_hold_tb;
    import sigmtr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_LEN    = 5;
    localparam int SEGMENT_COUNT = 25;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 100;
    // Leave ample room for a late result
    localparam int DRAIN_CYCLES  = 128;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // [11:0] sample, [21:12] elapsed_ms, [23:22] zero
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [4:0] level, [9:5] peak, [21:10] average, [23:22] zero
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int                   mismatch_count;
    int                   readings_due;
    int                   cycle_count   = 0;
    // Percent of cycles in which the sender idles / the receiver stalls
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    signal_meter_average_peak_hold #(
        .WINDOW_LEN    (WINDOW_LEN),
        .SEGMENT_COUNT (SEGMENT_COUNT)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    signal_meter_average_peak_hold_checker #(
        .WINDOW_LEN    (WINDOW_LEN),
        .SEGMENT_COUNT (SEGMENT_COUNT)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .readings_due   (readings_due)
    );

    // Stall the result channel at random; hold ready high when stalling is off
    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one sample transaction, idling first at random; return once accepted.
    // Valid stays high on return so back-to-back items need no extra edge.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [ELAPSED_W-1:0] ms);
        bit lowered = 1'b0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            if (!lowered) begin
                s_tvalid <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-SAMPLE_W-ELAPSED_W){1'b0}}, ms, smp};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every predicted reading has been delivered
    task automatic drain_readings();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (readings_due != 0);
    endtask

    // Write both registers back to back; the meter must be idle
    task automatic write_meter_config(input logic [SAMPLE_W-1:0] fs,
                                      input logic [DECAY_W-1:0] decay_ms);
        cfg_valid <= 1'b1;
        cfg_addr  <= CFG_FULL_SCALE;
        cfg_data  <= {{(CFG_DAT_W-SAMPLE_W){1'b0}}, fs};
        do @(posedge aclk); while (!cfg_ready);
        cfg_addr  <= CFG_DECAY_MS;
        cfg_data  <= decay_ms;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [SAMPLE_W-1:0]  smp;
        logic [ELAPSED_W-1:0] ms;
        logic [SAMPLE_W-1:0]  fs;
        logic [DECAY_W-1:0]   decay_ms;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings (full scale 2000, hold 150 ms)
        send_sample(12'd0, 10'd0);
        send_sample(12'hFFF, 10'h3FF);
        // Fill the whole ring with full-scale readings: largest running sum
        repeat (4) send_sample(12'hFFF, 10'd0);
        // Silence with long gaps: average falls, peak decays segment by segment
        repeat (5) send_sample(12'd0, 10'h3FF);
        // Alternating bit patterns on both fields
        send_sample(12'hAAA, 10'h2AA);
        send_sample(12'h555, 10'h155);
        // Averages just around full scale
        repeat (5) send_sample(12'd2000, 10'd1);
        send_sample(12'd1999, 10'd0);
        // Exactly at and just past the hold time
        send_sample(12'd0, 10'd150);
        send_sample(12'd0, 10'd151);
        drain_readings();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin fs = 12'hFFF; decay_ms = 16'hFFFF; end
                1: begin fs = 12'd1;   decay_ms = 16'd0;    end
                // Zero full scale lights every segment
                2: begin fs = 12'd0;   decay_ms = 16'd150;  end
                3: begin fs = 12'd2000; decay_ms = 16'd150; end
                4: begin fs = 12'd100; decay_ms = 16'd1023; end
                5: begin
                    fs       = SAMPLE_W'($urandom_range(4095, 1));
                    decay_ms = DECAY_W'($urandom_range(2000));
                end
                6: begin fs = 12'hFFF; decay_ms = 16'd0;    end
                default: begin
                    fs       = SAMPLE_W'($urandom_range(4095));
                    decay_ms = DECAY_W'($urandom_range(65535));
                end
            endcase
            write_meter_config(fs, decay_ms);

            // Rotate through the idling modes
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase

            // Mix uniform readings with loud bursts and quiet stretches so the
            // peak both climbs and decays; elapsed times cluster below the hold
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: smp = SAMPLE_W'($urandom_range(4095));
                    4, 5, 6:    smp = SAMPLE_W'($urandom_range(4095, 1500));
                    default:    smp = SAMPLE_W'($urandom_range(200));
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: ms = ELAPSED_W'($urandom_range(60));
                    5, 6, 7:       ms = ELAPSED_W'($urandom_range(1023));
                    8:             ms = '0;
                    default:       ms = '1;
                endcase
                send_sample(smp, ms);
            end
            drain_readings();
        end

        // Hold a while longer to catch any stray result
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && readings_due == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
